FILE: hw/rtl/flc_pkg.sv
package flc_pkg;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_CONVERT = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} flc_qstat_t;

	function automatic logic [16:0] atan_hturn(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:    v = 17'd16384;
			5'd1:    v = 17'd9672;
			5'd2:    v = 17'd5110;
			5'd3:    v = 17'd2594;
			5'd4:    v = 17'd1302;
			5'd5:    v = 17'd652;
			5'd6:    v = 17'd326;
			5'd7:    v = 17'd163;
			5'd8:    v = 17'd81;
			5'd9:    v = 17'd41;
			5'd10:   v = 17'd20;
			5'd11:   v = 17'd10;
			5'd12:   v = 17'd5;
			5'd13:   v = 17'd3;
			5'd14:   v = 17'd1;
			5'd15:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] to_byte(input logic [16:0] c);
		logic [24:0] pr;
		pr = {c, 8'b0} - {8'b0, c};
		return pr[23:16];
	endfunction

endpackage

FILE: hw/rtl/flc_queue.sv
module flc_queue #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [WIDTH-1:0]          push_data,
	input  logic                      pop,
	output logic [WIDTH-1:0]          head_data,
	output flc_pkg::flc_qstat_t       qstat
);
	import flc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;

	assign qstat.full  = (count_q == (PW+1)'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/flc_front.sv
module flc_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              mode,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic signed [SAMPLE_WIDTH-1:0]    x_component,
	input  logic signed [SAMPLE_WIDTH-1:0]    y_component,
	input  flc_pkg::flc_qstat_t               qstat,
	output logic                              push,
	output logic [2*SAMPLE_WIDTH+63:0]        push_data
);
	import flc_pkg::*;

	localparam int SW = SAMPLE_WIDTH;

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_SQX   = 2'd1;
	localparam logic [1:0] F_SQY   = 2'd2;
	localparam logic [1:0] F_ISSUE = 2'd3;

	logic [1:0]           st_q;
	logic [1:0]           op_q;
	logic [SW-1:0]        x_q, y_q;
	logic [2*SW-1:0]      xx_q;
	logic [31:0]          n2_q;
	logic [31:0]          max_q;
	logic [SW-1:0]        mag_x, mag_y;
	logic [2*SW-1:0]      yy;
	logic [64:0]          sum65;

	assign in_stall = (st_q != F_IDLE);
	assign mag_x    = x_q[SW-1] ? (~x_q + 1'b1) : x_q;
	assign mag_y    = y_q[SW-1] ? (~y_q + 1'b1) : y_q;
	assign yy       = mag_y * mag_y;
	assign sum65    = 65'(xx_q) + (mode ? 65'(yy) : 65'd0);

	assign push      = (st_q == F_ISSUE) && (op_q == OP_CONVERT) && !qstat.full;
	assign push_data = {x_q, y_q, n2_q, max_q};

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q <= opcode;
			x_q  <= x_component;
			y_q  <= y_component;
		end
		if (st_q == F_SQX) begin
			xx_q <= mag_x * mag_x;
		end
		if (st_q == F_SQY) begin
			n2_q <= (sum65 > 65'h0FFFFFFFF) ? 32'hFFFFFFFF : sum65[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_IDLE;
			max_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						st_q <= F_SQX;
					end
				end
				F_SQX: st_q <= F_SQY;
				F_SQY: st_q <= F_ISSUE;
				F_ISSUE: begin
					case (op_q)
						OP_CLEAR: begin
							max_q <= '0;
							st_q  <= F_IDLE;
						end
						OP_MEASURE: begin
							if (n2_q > max_q) begin
								max_q <= n2_q;
							end
							st_q <= F_IDLE;
						end
						OP_CONVERT: begin
							if (!qstat.full) begin
								st_q <= F_IDLE;
							end
						end
						default: st_q <= F_IDLE;
					endcase
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/flc_back.sv
module flc_back #(
	parameter int SAMPLE_WIDTH      = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mode,
	input  flc_pkg::flc_qstat_t           qstat,
	input  logic [2*SAMPLE_WIDTH+63:0]    head_data,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);
	import flc_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = SAMPLE_WIDTH + 3;
	localparam int QW = 2*SAMPLE_WIDTH + 64;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV  = 3'd1;
	localparam logic [2:0] B_SQRT = 3'd2;
	localparam logic [2:0] B_MUL1 = 3'd3;
	localparam logic [2:0] B_MUL2 = 3'd4;
	localparam logic [2:0] B_OUT  = 3'd5;

	localparam logic [16:0] ONE = 17'h10000;

	logic [2:0]           st_q;
	logic                 xpos_q;
	logic [31:0]          n2_q, m_q;
	logic [31:0]          rem_q, num_lo_q, quo_q;
	logic [4:0]           cnt_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [17:0]   z_q;
	logic [4:0]           it_q;
	logic [31:0]          a_q, r_q, bit_q;
	logic [16:0]          s_q, p1_q, p2_q;
	logic [15:0]          f_q;
	logic [2:0]           hi_q;
	logic [7:0]           gray_q;
	logic                 out_valid_q;
	logic [7:0]           red_q, green_q, blue_q;

	logic signed [SW-1:0] hx, hy;
	logic [31:0]          hn2, hm;
	logic [47:0]          dnum;
	logic [63:0]          num;
	logic signed [CW-1:0] xe, ye;
	logic [32:0]          dt;
	logic                 dge;
	logic [32:0]          sq_trial;
	logic                 sq_ge;
	logic [16:0]          s_sel;
	logic [15:0]          hue;
	logic [18:0]          h6;
	logic [32:0]          prod1;
	logic [33:0]          prod2;
	logic [16:0]          cp, cq, ct;
	logic [16:0]          cr, cg, cb;
	logic [7:0]           nr, ng, nb;
	logic                 out_free;

	assign hx   = head_data[QW-1 -: SW];
	assign hy   = head_data[QW-SW-1 -: SW];
	assign hn2  = head_data[63:32];
	assign hm   = head_data[31:0];
	assign dnum = 48'(hn2) * 48'd65025;
	assign num  = mode ? {hn2, 32'b0} : 64'(dnum);
	assign xe   = CW'(hx);
	assign ye   = CW'(hy);

	assign pop = (st_q == B_IDLE) && !qstat.empty;

	assign dt  = {rem_q, num_lo_q[31]};
	assign dge = (dt >= {1'b0, m_q});

	assign sq_trial = {1'b0, r_q} + {1'b0, bit_q};
	assign sq_ge    = ({1'b0, a_q} >= sq_trial);

	assign s_sel = (n2_q >= m_q) ? ONE : r_q[16:0];
	assign hue   = 16'(z_q + 18'sd32768);
	assign h6    = 19'(hue) * 19'd6;
	assign prod1 = 33'(s_sel) * 33'(h6[15:0]);
	assign prod2 = 34'(s_q) * 34'(ONE - {1'b0, f_q});

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	always_comb begin
		cp = ONE - s_q;
		cq = ONE - p1_q;
		ct = ONE - p2_q;
		case (hi_q)
			3'd0: begin cr = ONE; cg = ct;  cb = cp;  end
			3'd1: begin cr = cq;  cg = ONE; cb = cp;  end
			3'd2: begin cr = cp;  cg = ONE; cb = ct;  end
			3'd3: begin cr = cp;  cg = cq;  cb = ONE; end
			3'd4: begin cr = ct;  cg = cp;  cb = ONE; end
			default: begin cr = ONE; cg = cp; cb = cq; end
		endcase
		if (m_q == '0) begin
			nr = '0; ng = '0; nb = '0;
		end else if (mode) begin
			nr = to_byte(cr);
			ng = to_byte(cg);
			nb = to_byte(cb);
		end else begin
			nr = gray_q; ng = gray_q; nb = gray_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			xpos_q   <= !hx[SW-1] && (hx != '0);
			n2_q     <= hn2;
			m_q      <= hm;
			rem_q    <= num[63:32];
			num_lo_q <= num[31:0];
			cx_q     <= hx[SW-1] ? -xe : xe;
			cy_q     <= hx[SW-1] ? -ye : ye;
			z_q      <= '0;
			it_q     <= '0;
		end else begin
			if (it_q < 5'(CORDIC_ITERATIONS)) begin
				if (cy_q > 0) begin
					cx_q <= cx_q + (cy_q >>> it_q);
					cy_q <= cy_q - (cx_q >>> it_q);
					z_q  <= z_q + $signed({1'b0, atan_hturn(it_q)});
				end else begin
					cx_q <= cx_q - (cy_q >>> it_q);
					cy_q <= cy_q + (cx_q >>> it_q);
					z_q  <= z_q - $signed({1'b0, atan_hturn(it_q)});
				end
				it_q <= it_q + 1'b1;
			end
		end
		if (st_q == B_DIV) begin
			rem_q    <= dge ? 32'(dt - {1'b0, m_q}) : dt[31:0];
			num_lo_q <= {num_lo_q[30:0], 1'b0};
			quo_q    <= {quo_q[30:0], dge};
			if (cnt_q == 5'd31) begin
				a_q   <= {quo_q[30:0], dge};
				r_q   <= '0;
				bit_q <= 32'h40000000;
			end
		end
		if (st_q == B_SQRT) begin
			if (sq_ge) begin
				a_q <= 32'({1'b0, a_q} - sq_trial);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (st_q == B_MUL1) begin
			s_q  <= s_sel;
			f_q  <= h6[15:0];
			hi_q <= h6[18:16];
			p1_q <= prod1[32:16];
			if (!xpos_q) begin
				gray_q <= '0;
			end else if (n2_q >= m_q) begin
				gray_q <= 8'd255;
			end else begin
				gray_q <= (r_q > 32'd255) ? 8'd255 : r_q[7:0];
			end
		end
		if (st_q == B_MUL2) begin
			p2_q <= prod2[32:16];
		end
		if (st_q == B_OUT && out_free) begin
			red_q   <= nr;
			green_q <= ng;
			blue_q  <= nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						st_q  <= B_DIV;
						cnt_q <= '0;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						st_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if (bit_q == 32'd1) begin
						st_q <= B_MUL1;
					end
				end
				B_MUL1: st_q <= B_MUL2;
				B_MUL2: st_q <= B_OUT;
				B_OUT: begin
					if (out_free) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/flow_disparity_colorizer.sv
// channel   | handshake            | payload
// in        | in_valid / in_stall  | opcode, x_component, y_component
// out       | out_valid / out_stall| red, green, blue
// cfg       | cfg_wr_en            | cfg_wr_data (vector_mode)
//
// Front takes one beat at a time: two squaring steps, then max clear/update or queue push.
// Back handles a convert beat as a pop, 32 divide steps, 16 square-root
// steps (CORDIC overlaps the divide), two multiply states and one output load.
// A 4-entry queue sits between front and back; output register holds a result while stalled.
// Reset clears the running maximum, the queue and sets vector_mode to 1.
module flow_disparity_colorizer #(
	parameter int SAMPLE_WIDTH      = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic signed [SAMPLE_WIDTH-1:0] x_component,
	input  logic signed [SAMPLE_WIDTH-1:0] y_component,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue
);
	import flc_pkg::*;

	localparam int QW = 2*SAMPLE_WIDTH + 64;

	logic              mode_q;
	logic              push, pop;
	logic [QW-1:0]     push_data, head_data;
	flc_qstat_t        qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	flc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.x_component (x_component),
		.y_component (y_component),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	flc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.qstat     (qstat)
	);

	flc_back #(
		.SAMPLE_WIDTH      (SAMPLE_WIDTH),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.qstat     (qstat),
		.head_data (head_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

FILE: hw/rtl/flc_checker.sv
module flc_props (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_wr_en,
	input logic       cfg_wr_data,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);
	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled output beat changed");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_q |-> (red == green) && (green == blue))
		else $error("disparity beat is not gray");

	a_value_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q |-> (red == 8'd255) || (green == 8'd255) || (blue == 8'd255)
			|| ((red == 8'd0) && (green == 8'd0) && (blue == 8'd0)))
		else $error("flow beat has no full channel");

endmodule

bind flow_disparity_colorizer flc_props u_flc_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_wr_en   (cfg_wr_en),
	.cfg_wr_data (cfg_wr_data),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.red         (red),
	.green       (green),
	.blue        (blue)
);
